/* hw/rtl/oah_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_pkg: shared types and constants
// Slot geometry, request/response payloads and slot memory access structs
// for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oah_pkg;

  // Slot count, a power of two: the home slot is the low hash bits.
  localparam int unsigned TABLE_SLOTS = 256;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned USED_W      = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned LIMIT_W     = 8;
  // Width for the load check, wide enough for used+1 and for the limit.
  localparam int unsigned CMP_W       = (USED_W + 1 > LIMIT_W + 1) ? USED_W + 1 : LIMIT_W + 1;

  // 0.75 of 256 slots
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_EXISTS = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] value_out;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
  } mem_rd_t;

  typedef struct packed {
    logic        tag_we;
    logic        val_we;
    slot_idx_t   addr;
    tag_e        tag;
    logic [31:0] key;
    logic [63:0] value;
  } mem_wr_t;

  typedef struct packed {
    tag_e        tag;
    logic [31:0] key;
    logic [63:0] value;
  } mem_rsp_t;

endpackage

/* hw/rtl/oah_slot_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_slot_mem: slot storage
// Tag/key memory and value memory, one read and one write port each, read
// data registered. Per-slot written flags make unwritten slots read empty.
// ----------------------------------------------------------------------------
module oah_slot_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oah_pkg::mem_rd_t  rd_i,
  input  oah_pkg::mem_wr_t  wr_i,
  output oah_pkg::mem_rsp_t rsp_o
);

  typedef struct packed {
    oah_pkg::tag_e tag;
    logic [31:0]   key;
  } entry_t;

  entry_t      tag_mem [oah_pkg::TABLE_SLOTS];
  logic [63:0] val_mem [oah_pkg::TABLE_SLOTS];

  logic [oah_pkg::TABLE_SLOTS-1:0] written_q;
  logic                            rd_written_q;
  entry_t                          rd_entry_q;
  logic [63:0]                     rd_value_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we) begin
      tag_mem[wr_i.addr] <= '{tag: wr_i.tag, key: wr_i.key};
    end
    if (wr_i.val_we) begin
      val_mem[wr_i.addr] <= wr_i.value;
    end
    if (rd_i.en) begin
      rd_entry_q <= tag_mem[rd_i.addr];
      rd_value_q <= val_mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.tag_we) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_written_q <= written_q[rd_i.addr];
      end
    end
  end

  assign rsp_o.tag   = rd_written_q ? rd_entry_q.tag : oah_pkg::TAG_EMPTY;
  assign rsp_o.key   = rd_entry_q.key;
  assign rsp_o.value = rd_value_q;

endmodule

/* hw/rtl/oah_probe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oah_probe: request sequencer
// Walks the probe path one slot read per cycle, applies set/delete write
// back at the end of the walk and keeps the used-slot count.
// ----------------------------------------------------------------------------
module oah_probe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [oah_pkg::LIMIT_W-1:0]   load_limit_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  oah_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output oah_pkg::rsp_t                 res_o,
  output oah_pkg::mem_rd_t              mem_rd_o,
  output oah_pkg::mem_wr_t              mem_wr_o,
  input  oah_pkg::mem_rsp_t             mem_rsp_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

  state_e                       state_q, state_d;
  oah_pkg::req_t                req_q, req_d;
  oah_pkg::rsp_t                res_q, res_d;
  oah_pkg::slot_idx_t           idx_q, idx_d;
  oah_pkg::slot_idx_t           cnt_q, cnt_d;
  oah_pkg::slot_idx_t           tomb_q, tomb_d;
  logic                         tomb_seen_q, tomb_seen_d;
  logic [oah_pkg::USED_W-1:0]   used_q, used_d;

  oah_pkg::slot_idx_t           idx_nxt, free_idx;
  logic                         over_limit, last, is_set;
  logic                         is_empty, is_hit, is_tomb, free_ok, fresh;

  assign over_limit = (oah_pkg::CMP_W'(used_q) + oah_pkg::CMP_W'(1))
                      > oah_pkg::CMP_W'(load_limit_i);
  assign idx_nxt    = (idx_q == oah_pkg::SLOT_W'(oah_pkg::TABLE_SLOTS - 1))
                      ? '0 : idx_q + oah_pkg::SLOT_W'(1);
  assign last       = (cnt_q == oah_pkg::SLOT_W'(oah_pkg::TABLE_SLOTS - 1));
  assign is_set     = (req_q.mode == oah_pkg::MODE_SET);
  assign is_empty   = (mem_rsp_i.tag == oah_pkg::TAG_EMPTY);
  assign is_tomb    = (mem_rsp_i.tag == oah_pkg::TAG_TOMB);
  assign is_hit     = (mem_rsp_i.tag == oah_pkg::TAG_LIVE) && (mem_rsp_i.key == req_q.key_id);
  // earliest tombstone wins, else the slot under evaluation
  assign free_idx   = tomb_seen_q ? tomb_q : idx_q;
  assign free_ok    = tomb_seen_q || is_tomb || is_empty;
  assign fresh      = !tomb_seen_q && is_empty;

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    tomb_d      = tomb_q;
    tomb_seen_d = tomb_seen_q;
    used_d      = used_q;
    mem_rd_o    = '0;
    mem_wr_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          if (req_i.mode == oah_pkg::MODE_SET && over_limit) begin
            res_d.status = 1'b1;
            state_d      = ST_DONE;
          end else if (req_i.mode != oah_pkg::MODE_SET && used_q == '0) begin
            state_d = ST_DONE;
          end else begin
            mem_rd_o.en   = 1'b1;
            mem_rd_o.addr = req_i.key_hash[oah_pkg::SLOT_W-1:0];
            idx_d         = req_i.key_hash[oah_pkg::SLOT_W-1:0];
            cnt_d         = '0;
            tomb_seen_d   = 1'b0;
            state_d       = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        // prefetch the next slot; dropped if the walk ends here
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = idx_nxt;
        idx_d         = idx_nxt;
        cnt_d         = cnt_q + oah_pkg::SLOT_W'(1);
        if (is_hit) begin
          state_d         = ST_DONE;
          res_d.found     = !is_set;
          res_d.value_out = (req_q.mode == oah_pkg::MODE_GET) ? mem_rsp_i.value : '0;
          if (is_set) begin
            mem_wr_o.val_we = 1'b1;
            mem_wr_o.addr   = idx_q;
            mem_wr_o.value  = req_q.value_in;
          end else if (req_q.mode == oah_pkg::MODE_DELETE) begin
            mem_wr_o.tag_we = 1'b1;
            mem_wr_o.addr   = idx_q;
            mem_wr_o.tag    = oah_pkg::TAG_TOMB;
            mem_wr_o.key    = mem_rsp_i.key;
          end
        end else if (is_empty || last) begin
          state_d = ST_DONE;
          if (is_set) begin
            if (free_ok) begin
              res_d.found     = 1'b1;
              mem_wr_o.tag_we = 1'b1;
              mem_wr_o.val_we = 1'b1;
              mem_wr_o.addr   = free_idx;
              mem_wr_o.tag    = oah_pkg::TAG_LIVE;
              mem_wr_o.key    = req_q.key_id;
              mem_wr_o.value  = req_q.value_in;
              if (fresh) begin
                used_d = used_q + oah_pkg::USED_W'(1);
              end
            end else begin
              res_d.status = 1'b1;
            end
          end
        end else if (is_tomb && !tomb_seen_q) begin
          tomb_d      = idx_q;
          tomb_seen_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      tomb_seen_q <= 1'b0;
      req_q       <= '0;
      res_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      tomb_q      <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      tomb_seen_q <= tomb_seen_d;
      req_q       <= req_d;
      res_q       <= res_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      tomb_q      <= tomb_d;
    end
  end

  // slot memory is only written at the end of a probe walk
  a_wr_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_o.tag_we || mem_wr_o.val_we) |-> state_q == ST_PROBE)
    else $error("slot write outside probe walk");

  // used count only grows, by one, and only with a live tag written
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      (used_q == $past(used_q) + oah_pkg::USED_W'(1)) && $past(mem_wr_o.tag_we)
      && ($past(mem_wr_o.tag) == oah_pkg::TAG_LIVE))
    else $error("bad used count update");

  // refusals only for sets, never with found
  a_refuse_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status) |-> (req_q.mode == oah_pkg::MODE_SET) && !res_o.found)
    else $error("refusal on non-set request");

  // used count bounded by the table size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= oah_pkg::USED_W'(oah_pkg::TABLE_SLOTS))
    else $error("used count overflow");

endmodule

/* hw/rtl/open_addressing_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table: linear-probing key/value table with tombstones
//
// Requests transfer on in_valid_i/in_ready_o (set, get, exists, delete), one
// response per request transfers on out_valid_o/out_ready_i, in order.
// cfg_valid_i/cfg_ready_o writes load_limit; cfg_ready_o is always high and
// writes are expected only while the table is idle.
// One request is worked at a time. A request walks its probe path with one slot
// memory read per cycle; refused sets and lookups on an empty table skip the
// walk and go straight to the response.
// The output register lets the next request enter while a response waits;
// if the receiver stalls, the following response holds inside the sequencer
// and input is not taken until the output register frees up.
// Reset clears all slot tags (per-slot written flags), the used count and
// sets load_limit to 192; no clearing pass is needed.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [oah_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  oah_pkg::req_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output oah_pkg::rsp_t               out_data_o
);

  logic [oah_pkg::LIMIT_W-1:0] load_limit_q;

  oah_pkg::mem_rd_t  mem_rd;
  oah_pkg::mem_wr_t  mem_wr;
  oah_pkg::mem_rsp_t mem_rsp;

  logic          res_valid, res_ready;
  oah_pkg::rsp_t res;

  logic          out_valid_q;
  oah_pkg::rsp_t out_q;

  // Config register: single load limit, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= oah_pkg::LOAD_LIMIT_RST;
    end else if (cfg_valid_i) begin
      load_limit_q <= cfg_data_i;
    end
  end

  oah_slot_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (mem_rd),
    .wr_i   (mem_wr),
    .rsp_o  (mem_rsp)
  );

  oah_probe u_probe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_limit_i (load_limit_q),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_i        (in_data_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_rd_o     (mem_rd),
    .mem_wr_o     (mem_wr),
    .mem_rsp_i    (mem_rsp)
  );

  // Output register: loads when empty or draining this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for open_addressing_hash_table
// A directed table comes first: the empty table, extreme keys and values,
// overwrite, delete, tombstone reuse, wrap of the probe past the last slot
// and refusals at the load limit. Random segments follow, each under its own
// load_limit. They use a small pool of clustered keys plus random keys as
// noise. A mirror of the table predicts every response, and the responses
// are checked in order. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb;
  import oah_pkg::*;

  localparam int unsigned NO_SLOT    = 32'hFFFF_FFFF;
  localparam int unsigned POOL_KEYS  = 48;
  localparam int unsigned STALL_MAX  = 4000;  // idle cycles before the watchdog fires
  localparam int unsigned MAX_PRINTS = 40;

  // Directed table row: either a load_limit write or a request. Typed rows
  // carry their response; the others are checked against the mirror.
  typedef struct {
    bit               is_cfg;
    logic [LIMIT_W-1:0] limit;
    req_t             req;
    bit               typed;
    rsp_t             rsp;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  req_t               in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  rsp_t               out_data_o;

  open_addressing_hash_table u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Mirror of the table: slot tags, keys, values, used count and load limit.
  // --------------------------------------------------------------------------
  tag_e               tag_mirror [TABLE_SLOTS];
  logic [31:0]        key_mirror [TABLE_SLOTS];
  logic [63:0]        val_mirror [TABLE_SLOTS];
  int unsigned        used_mirror;
  logic [LIMIT_W-1:0] limit_mirror;

  rsp_t        pending_rsp [$];   // responses still owed by the block, oldest first
  int unsigned mismatches;
  row_t        directed_rows [$];

  // Key pool: most keys cluster their home slots around the wrap point so
  // probe chains form and cross from the last slot back to slot 0.
  logic [31:0] pool_key  [POOL_KEYS];
  logic [31:0] pool_hash [POOL_KEYS];

  // Sender burst state.
  int unsigned send_gap;
  int unsigned burst_left;
  bit          in_held;     // valid left high after the last transfer

  // Receiver stall state.
  int unsigned rcv_cycle;
  int unsigned rcv_hold;

  int unsigned idle_cycles;

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: apply one request to the mirror and return its response.
  // Home slot is the hash modulo the slot count; probing walks upward with
  // wrap, stopping at an empty slot or a live match, and remembers the
  // earliest tombstone for reuse by a set.
  // --------------------------------------------------------------------------
  function automatic rsp_t hash_table_step(input req_t r);
    rsp_t        o;
    int unsigned idx;
    int unsigned n;
    int unsigned tomb;
    int unsigned hit;
    int unsigned free_slot;
    bit          done;
    o         = '0;
    hit       = NO_SLOT;
    free_slot = NO_SLOT;
    if (r.mode == MODE_SET && used_mirror + 1 > int'(limit_mirror)) begin
      // load check comes first, even when the key is already live
      o.status = 1'b1;
    end else if (r.mode == MODE_SET || used_mirror != 0) begin
      idx  = r.key_hash % TABLE_SLOTS;
      tomb = NO_SLOT;
      done = 1'b0;
      for (n = 0; n < TABLE_SLOTS && !done; n++) begin
        if (tag_mirror[idx] == TAG_EMPTY) begin
          free_slot = (tomb != NO_SLOT) ? tomb : idx;
          done      = 1'b1;
        end else if (tag_mirror[idx] == TAG_LIVE) begin
          if (key_mirror[idx] == r.key_id) begin
            hit  = idx;
            done = 1'b1;
          end
        end else if (tomb == NO_SLOT) begin
          tomb = idx;
        end
        if (!done) idx = (idx + 1) % TABLE_SLOTS;
      end
      if (!done) free_slot = tomb;
      if (r.mode == MODE_SET) begin
        if (hit != NO_SLOT) begin
          val_mirror[hit] = r.value_in;
        end else if (free_slot == NO_SLOT) begin
          o.status = 1'b1;
        end else begin
          // only filling an empty slot grows the count; tombstone reuse does not
          if (tag_mirror[free_slot] == TAG_EMPTY) used_mirror = used_mirror + 1;
          tag_mirror[free_slot] = TAG_LIVE;
          key_mirror[free_slot] = r.key_id;
          val_mirror[free_slot] = r.value_in;
          o.found               = 1'b1;
        end
      end else if (hit != NO_SLOT) begin
        o.found = 1'b1;
        if (r.mode == MODE_GET) o.value_out = val_mirror[hit];
        else if (r.mode == MODE_DELETE) tag_mirror[hit] = TAG_TOMB;
      end
    end
    return o;
  endfunction

  function automatic row_t req_row(input mode_e m, input logic [31:0] k,
                                   input logic [31:0] h, input logic [63:0] v);
    row_t row;
    row              = '{default: '0};
    row.req.mode     = m;
    row.req.key_id   = k;
    row.req.key_hash = h;
    row.req.value_in = v;
    return row;
  endfunction

  function automatic row_t chk_row(input mode_e m, input logic [31:0] k,
                                   input logic [31:0] h, input logic [63:0] v,
                                   input logic f, input logic [63:0] vo, input logic s);
    row_t row;
    row               = req_row(m, k, h, v);
    row.typed         = 1'b1;
    row.rsp.found     = f;
    row.rsp.value_out = vo;
    row.rsp.status    = s;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [LIMIT_W-1:0] lim);
    row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.limit  = lim;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: mismatch %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver. Valid goes up at a clock edge and holds with its payload
  // until the transfer. Between bursts valid drops for a random gap; inside
  // a burst it stays high and only the payload changes.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t pred;
    repeat (send_gap) @(posedge clk_i);
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = hash_table_step(r);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    if (burst_left > 0) begin
      burst_left--;
      send_gap = 0;
    end else begin
      burst_left = $urandom_range(0, 40);
      send_gap   = $urandom_range(1, 12);
    end
    if (send_gap != 0) in_valid_i <= 1'b0;
    in_held = (send_gap == 0);
  endtask

  // Sender goes quiet until every owed response is back, then load_limit is
  // written. Every request yields a response, so an empty queue means idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    if (in_held) in_valid_i <= 1'b0;
    in_held = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_data_i  <= lim;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    limit_mirror = lim;
  endtask

  // Random segment: pool keys with random content (now and then under a wrong
  // hash), plus noise of fresh random keys at the given percentage.
  task automatic run_random(input int unsigned count, input int unsigned noise_pct);
    req_t        r;
    rsp_t        none;
    int unsigned p;
    int unsigned w;
    none = '0;
    for (int unsigned i = 0; i < count; i++) begin
      p = $urandom_range(0, POOL_KEYS - 1);
      w = $urandom_range(0, 99);
      if (w < noise_pct) begin
        r.key_id   = $urandom;
        r.key_hash = $urandom;
      end else begin
        r.key_id   = pool_key[p];
        r.key_hash = ($urandom_range(0, 19) == 0) ? $urandom : pool_hash[p];
      end
      w = $urandom_range(0, 99);
      if (w < 40)      r.mode = MODE_SET;
      else if (w < 65) r.mode = MODE_GET;
      else if (w < 80) r.mode = MODE_EXISTS;
      else             r.mode = MODE_DELETE;
      r.value_in = {$urandom, $urandom};
      send_req(r, 1'b0, none);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready pattern cycles through four regimes, picked by bits 9:8 of
  // rcv_cycle: always ready, light random stalls, rare long stalls, and alternating.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rcv_cycle = rcv_cycle + 1;
    case (rcv_cycle[9:8])
      2'd0: begin
        out_ready_i <= 1'b1;
      end
      2'd1: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      2'd2: begin
        if (rcv_hold > 0) begin
          rcv_hold    = rcv_hold - 1;
          out_ready_i <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rcv_hold    = $urandom_range(1, 20);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
      default: begin
        out_ready_i <= rcv_cycle[0];
      end
    endcase
  end

  // Response checker: each response transfer is held against the oldest
  // owed response, field by field.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", 64'(out_data_o), '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.found !== want.found)
          report_mismatch("found", 64'(out_data_o.found), 64'(want.found));
        if (out_data_o.value_out !== want.value_out)
          report_mismatch("value_out", out_data_o.value_out, want.value_out);
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
      end
    end
  end

  // Watchdog: too long with no transfer on any channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned lim;
    clk_i       = 1'b0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    rcv_cycle   = 0;
    rcv_hold    = 0;
    send_gap    = 0;
    burst_left  = 0;
    in_held     = 1'b0;

    // mirror after reset: all slots empty, limit at its reset value
    foreach (tag_mirror[i]) begin
      tag_mirror[i] = TAG_EMPTY;
      key_mirror[i] = '0;
      val_mirror[i] = '0;
    end
    used_mirror  = 0;
    limit_mirror = LOAD_LIMIT_RST;

    for (int unsigned i = 0; i < POOL_KEYS; i++) begin
      pool_key[i]  = $urandom;
      pool_hash[i] = $urandom;
      if (i < POOL_KEYS * 3 / 4) pool_hash[i][7:0] = 8'(248 + $urandom_range(0, 23));
    end

    // Directed part, under the reset load_limit first.
    // empty table: lookups and delete miss without probing
    directed_rows.push_back(chk_row(MODE_GET, 32'h0, 32'h0, 64'h0, 1'b0, 64'h0, 1'b0));
    directed_rows.push_back(chk_row(MODE_EXISTS, '1, '1, '1, 1'b0, 64'h0, 1'b0));
    directed_rows.push_back(chk_row(MODE_DELETE, 32'h0, 32'h0, 64'h0, 1'b0, 64'h0, 1'b0));
    // extreme keys and values, fresh inserts
    directed_rows.push_back(chk_row(MODE_SET, 32'h0, 32'h0, 64'h0, 1'b1, 64'h0, 1'b0));
    directed_rows.push_back(chk_row(MODE_SET, '1, '1, '1, 1'b1, 64'h0, 1'b0));
    directed_rows.push_back(chk_row(MODE_GET, '1, '1, 64'h0, 1'b1, '1, 1'b0));
    directed_rows.push_back(chk_row(MODE_GET, 32'h0, 32'h0, '1, 1'b1, 64'h0, 1'b0));
    // overwrite of a live key reports not-new
    directed_rows.push_back(chk_row(MODE_SET, 32'h0, 32'h0, 64'h5555_5555_5555_5555,
                                    1'b0, 64'h0, 1'b0));
    // collisions on home slot 0, and a chain that wraps from the last slot
    directed_rows.push_back(req_row(MODE_SET, 32'h1, 32'hFFFF_FF00, 64'hA5A5_A5A5_0000_0001));
    directed_rows.push_back(req_row(MODE_SET, 32'h2, 32'h1234_5600, 64'h0F0F_0F0F_0000_0002));
    directed_rows.push_back(req_row(MODE_SET, 32'h3, 32'hFFFF_FFFF, 64'h8000_0000_0000_0003));
    // delete leaves a tombstone; lookups walk past it
    directed_rows.push_back(chk_row(MODE_DELETE, 32'h1, 32'hFFFF_FF00, 64'h0,
                                    1'b1, 64'h0, 1'b0));
    directed_rows.push_back(chk_row(MODE_GET, 32'h1, 32'hFFFF_FF00, 64'h0, 1'b0, 64'h0, 1'b0));
    directed_rows.push_back(req_row(MODE_GET, 32'h2, 32'h1234_5600, 64'h0));
    // tombstone reuse by a different key
    directed_rows.push_back(req_row(MODE_SET, 32'h4, 32'h0000_0000, 64'h1234_5678_9ABC_DEF0));
    directed_rows.push_back(req_row(MODE_EXISTS, 32'h4, 32'h0000_0000, 64'h0));
    directed_rows.push_back(req_row(MODE_DELETE, 32'h3, 32'hFFFF_FFFF, 64'h0));
    directed_rows.push_back(req_row(MODE_SET, 32'h3, 32'hFFFF_FFFF, 64'h0000_0000_0000_0033));
    directed_rows.push_back(req_row(MODE_EXISTS, 32'h9, 32'h0000_0080, 64'h0));
    // limit of one: every set refused, even for a live key
    directed_rows.push_back(cfg_row(8'd1));
    directed_rows.push_back(chk_row(MODE_SET, 32'h0, 32'h0, 64'h1, 1'b0, 64'h0, 1'b1));
    directed_rows.push_back(chk_row(MODE_SET, 32'h77, 32'h77, 64'h2, 1'b0, 64'h0, 1'b1));
    directed_rows.push_back(req_row(MODE_GET, 32'h0, 32'h0, 64'h0));
    // highest limit
    directed_rows.push_back(cfg_row(8'd255));
    directed_rows.push_back(req_row(MODE_SET, 32'hDEAD_BEEF, 32'h0000_007F,
                                    64'hC3C3_3C3C_F00D_CAFE));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_limit(directed_rows[i].limit);
      else send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Random part, one load_limit per segment.
    run_random(600, 15);
    write_limit(8'($urandom_range(1, 255)));
    run_random(300, 20);
    // limit just above the current fill, so new keys soon hit the refusal
    lim = used_mirror + 3;
    if (lim > 255) lim = 255;
    write_limit(8'(lim));
    run_random(300, 30);
    // heavy noise at the top limit fills the table toward its limit,
    // giving long probe chains and refusals
    write_limit(8'd255);
    run_random(600, 60);

    if (in_held) in_valid_i <= 1'b0;
    in_held = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
